### design/pedf_pkg.sv
// Package for the priority EDF slice scheduler.
// Holds the beat types, the queue entry type, the status codes and the cell op struct.
// No dependencies.
`default_nettype none
package pedf_pkg;

  localparam logic [15:0] QUANTUM_RESET = 16'd10;
  localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REQUEUED = 3'd2,
    ST_FINISHED = 3'd3,
    ST_DROPPED  = 3'd4,
    ST_IDLE     = 3'd5
  } status_t;

  localparam logic MODE_ADD      = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  task_id;
    logic [2:0]  priority_req;
    logic [15:0] burst;
    logic [31:0] deadline;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  served_id;
    logic [2:0]  served_level;
    logic [31:0] start_time;
    logic [15:0] slice_len;
    logic [15:0] remaining;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
    logic [31:0] deadline;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_op_t;

endpackage
`default_nettype wire

### design/priority_edf_slice_scheduler.sv
// Top level of the priority EDF slice scheduler: control, timekeeping and the level queues.
// Uses pedf_pkg and pedf_level.
//
// One item is taken at a time. An add is accepted in S_IDLE; in S_EXEC, once the output is
// free, its result is registered and the entry inserted into the level's cell chain. A
// dispatch that finishes, drops or idles takes the same path, and one that requeues holds
// the input through S_REQ while the remainder is inserted back into its level. Each queue
// is a chain of cells that shifts by one slot on an insert or removal, so neither depends
// on the fill. A result waiting on out_stall holds the controller before the next item's
// result is written.
`default_nettype none
module priority_edf_slice_scheduler #(
  parameter int LEVELS            = 8,
  parameter int ENTRIES_PER_LEVEL = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pedf_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pedf_pkg::out_beat_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [15:0]         cfg_wr_data
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW = $clog2(ENTRIES_PER_LEVEL + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_REQ  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  pedf_pkg::in_beat_t  req_r;
  logic [15:0]         quantum_r;
  logic [31:0]         time_r, time_nxt;
  logic                out_valid_r, out_valid_nxt;
  pedf_pkg::out_beat_t out_r, out_nxt;
  pedf_pkg::entry_t    rq_r, rq_nxt;
  logic [LW-1:0]       rq_lvl_r, rq_lvl_nxt;

  pedf_pkg::cell_op_t  ops [LEVELS];
  pedf_pkg::entry_t    heads [LEVELS];
  logic [CW-1:0]       counts [LEVELS];
  pedf_pkg::entry_t    push_entry;

  logic [LW-1:0] add_lvl;
  logic [LW-1:0] sel_lvl;
  logic          any_ne;
  logic          go;
  logic [15:0]   q_eff, run;
  logic [32:0]   slice_end;
  pedf_pkg::entry_t hd;

  genvar g;
  generate
    for (g = 0; g < LEVELS; g++) begin : g_lvl
      pedf_level #(.ENTRIES_PER_LEVEL(ENTRIES_PER_LEVEL)) u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (ops[g]),
        .new_entry (push_entry),
        .head      (heads[g]),
        .count     (counts[g])
      );
    end
  endgenerate

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign go        = !out_valid_r || !out_stall;

  always_comb begin
    if (32'(req_r.priority_req) >= 32'(LEVELS)) begin
      add_lvl = LW'(LEVELS - 1);
    end else begin
      add_lvl = LW'(req_r.priority_req);
    end
  end

  always_comb begin
    sel_lvl = '0;
    any_ne  = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (counts[l] != '0) begin
        sel_lvl = LW'(l);
        any_ne  = 1'b1;
      end
    end
  end

  assign hd        = heads[sel_lvl];
  assign q_eff     = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign run       = (hd.burst < q_eff) ? hd.burst : q_eff;
  assign slice_end = {1'b0, time_r} + {17'd0, run};

  always_comb begin
    state_nxt     = state_r;
    time_nxt      = time_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    rq_nxt        = rq_r;
    rq_lvl_nxt    = rq_lvl_r;
    push_entry    = '{id: req_r.task_id, burst: req_r.burst, deadline: req_r.deadline};
    for (int l = 0; l < LEVELS; l++) begin
      ops[l] = '{push: 1'b0, pop: 1'b0};
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          out_valid_nxt        = 1'b1;
          out_nxt.start_time   = time_r;
          out_nxt.slice_len    = 16'd0;
          state_nxt            = S_IDLE;
          if (req_r.mode == pedf_pkg::MODE_ADD) begin
            out_nxt.served_id    = req_r.task_id;
            out_nxt.served_level = 3'(add_lvl);
            out_nxt.remaining    = req_r.burst;
            if (counts[add_lvl] == CW'(ENTRIES_PER_LEVEL)) begin
              out_nxt.status = pedf_pkg::ST_FULL;
            end else begin
              out_nxt.status   = pedf_pkg::ST_ADDED;
              ops[add_lvl].push = 1'b1;
            end
          end else if (!any_ne) begin
            out_nxt.status       = pedf_pkg::ST_IDLE;
            out_nxt.served_id    = 8'd0;
            out_nxt.served_level = 3'd0;
            out_nxt.remaining    = 16'd0;
          end else begin
            ops[sel_lvl].pop     = 1'b1;
            out_nxt.served_id    = hd.id;
            out_nxt.served_level = 3'(sel_lvl);
            if (hd.burst == 16'd0) begin
              out_nxt.status    = pedf_pkg::ST_FINISHED;
              out_nxt.remaining = 16'd0;
            end else if (slice_end > {1'b0, hd.deadline}) begin
              out_nxt.status    = pedf_pkg::ST_DROPPED;
              out_nxt.remaining = hd.burst;
            end else begin
              time_nxt          = slice_end[32] ? pedf_pkg::TIME_MAX : slice_end[31:0];
              out_nxt.slice_len = run;
              out_nxt.remaining = hd.burst - run;
              if (hd.burst == run) begin
                out_nxt.status = pedf_pkg::ST_FINISHED;
              end else begin
                out_nxt.status = pedf_pkg::ST_REQUEUED;
                rq_nxt         = '{id: hd.id, burst: hd.burst - run, deadline: hd.deadline};
                rq_lvl_nxt     = sel_lvl;
                state_nxt      = S_REQ;
              end
            end
          end
        end
      end
      S_REQ: begin
        push_entry         = rq_r;
        ops[rq_lvl_r].push = 1'b1;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      quantum_r   <= pedf_pkg::QUANTUM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_data;
    end
    out_r    <= out_nxt;
    rq_r     <= rq_nxt;
    rq_lvl_r <= rq_lvl_nxt;
  end

endmodule
`default_nettype wire

### design/pedf_cell.sv
// One slot of a deadline-sorted level queue.
// Takes the new entry, its left neighbour's or its right neighbour's entry. Uses pedf_pkg.
`default_nettype none
module pedf_cell (
  input  wire logic             clk,
  input  wire pedf_pkg::cell_op_t op,
  input  wire logic             valid,
  input  wire logic             gt_prev,
  input  wire pedf_pkg::entry_t new_entry,
  input  wire pedf_pkg::entry_t prev_entry,
  input  wire pedf_pkg::entry_t next_entry,
  output logic                  gt,
  output pedf_pkg::entry_t      entry
);

  pedf_pkg::entry_t entry_r;
  pedf_pkg::entry_t entry_nxt;

  // later deadline or empty: new entry goes at or before this slot
  assign gt    = !valid || (entry_r.deadline > new_entry.deadline);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (op.pop) begin
      entry_nxt = next_entry;
    end else if (op.push && gt) begin
      entry_nxt = gt_prev ? prev_entry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

### design/pedf_level.sv
// One priority level: a chain of pedf_cell slots kept sorted by deadline, and its fill count.
// Uses pedf_pkg and pedf_cell.
`default_nettype none
module pedf_level #(
  parameter int ENTRIES_PER_LEVEL = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pedf_pkg::cell_op_t op,
  input  wire pedf_pkg::entry_t new_entry,
  output pedf_pkg::entry_t      head,
  output logic [$clog2(ENTRIES_PER_LEVEL+1)-1:0] count
);

  localparam int CW = $clog2(ENTRIES_PER_LEVEL + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [ENTRIES_PER_LEVEL-1:0] gt;
  pedf_pkg::entry_t ents [ENTRIES_PER_LEVEL];

  genvar i;
  generate
    for (i = 0; i < ENTRIES_PER_LEVEL; i++) begin : g_cell
      logic             gt_p;
      pedf_pkg::entry_t prev_e;
      pedf_pkg::entry_t next_e;
      if (i == 0) begin : g_first
        assign gt_p   = 1'b0;
        assign prev_e = new_entry;
      end else begin : g_mid
        assign gt_p   = gt[i-1];
        assign prev_e = ents[i-1];
      end
      if (i == ENTRIES_PER_LEVEL - 1) begin : g_last
        assign next_e = new_entry;
      end else begin : g_body
        assign next_e = ents[i+1];
      end
      pedf_cell u_cell (
        .clk        (clk),
        .op         (op),
        .valid      (CW'(i) < count_r),
        .gt_prev    (gt_p),
        .new_entry  (new_entry),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .gt         (gt[i]),
        .entry      (ents[i])
      );
    end
  endgenerate

  assign head  = ents[0];
  assign count = count_r;

  always_comb begin
    count_nxt = count_r;
    if (op.pop) begin
      count_nxt = count_r - CW'(1);
    end else if (op.push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for priority_edf_slice_scheduler.
// Predicts each result beat with a class model of the level queues and clock; needs pedf_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int LEVELS = 8;
  localparam int DEPTH  = 16;

  class sched_scoreboard;
    pedf_pkg::entry_t    slots[LEVELS][DEPTH];
    int                  fill[LEVELS];
    logic [31:0]         now;
    logic [15:0]         quantum;
    pedf_pkg::out_beat_t pending[$];
    int                  mismatches;

    function void clear();
      for (int l = 0; l < LEVELS; l++) fill[l] = 0;
      now = 0;
      quantum = pedf_pkg::QUANTUM_RESET;
      pending.delete();
      mismatches = 0;
    endfunction

    function bit insert(int l, pedf_pkg::entry_t e);
      int pos;
      pos = 0;
      if (fill[l] >= DEPTH) return 0;
      while (pos < fill[l] && slots[l][pos].deadline <= e.deadline) pos++;
      for (int k = fill[l]; k > pos; k--) slots[l][k] = slots[l][k-1];
      slots[l][pos] = e;
      fill[l]++;
      return 1;
    endfunction

    function void note_input(pedf_pkg::in_beat_t b);
      pedf_pkg::out_beat_t r;
      pedf_pkg::entry_t    t;
      int                  l;
      logic [15:0]         q, run;
      logic [32:0]         fin;
      r = '0;
      r.start_time = now;
      if (b.mode == pedf_pkg::MODE_ADD) begin
        t.id = b.task_id; t.burst = b.burst; t.deadline = b.deadline;
        r.status = insert(b.priority_req, t) ? pedf_pkg::ST_ADDED : pedf_pkg::ST_FULL;
        r.served_id = b.task_id;
        r.served_level = b.priority_req;
        r.remaining = b.burst;
      end else begin
        l = 0;
        while (l < LEVELS && fill[l] == 0) l++;
        if (l >= LEVELS) begin
          r.status = pedf_pkg::ST_IDLE;
        end else begin
          t = slots[l][0];
          for (int k = 1; k < fill[l]; k++) slots[l][k-1] = slots[l][k];
          fill[l]--;
          r.served_id = t.id;
          r.served_level = 3'(l);
          q = (quantum == 0) ? 16'd1 : quantum;
          if (t.burst == 0) begin
            r.status = pedf_pkg::ST_FINISHED;
          end else begin
            run = (t.burst < q) ? t.burst : q;
            fin = {1'b0, now} + {17'd0, run};
            if (fin > {1'b0, t.deadline}) begin
              r.status = pedf_pkg::ST_DROPPED;
              r.remaining = t.burst;
            end else begin
              now = fin[32] ? pedf_pkg::TIME_MAX : fin[31:0];
              r.slice_len = run;
              r.remaining = t.burst - run;
              if (r.remaining == 0) begin
                r.status = pedf_pkg::ST_FINISHED;
              end else begin
                t.burst = r.remaining;
                void'(insert(l, t));
                r.status = pedf_pkg::ST_REQUEUED;
              end
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(pedf_pkg::out_beat_t got);
      pedf_pkg::out_beat_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: st %0d/%0d id %0d/%0d lvl %0d/%0d t %0d/%0d run %0d/%0d rem %0d/%0d",
                   want.status, got.status, want.served_id, got.served_id,
                   want.served_level, got.served_level, want.start_time, got.start_time,
                   want.slice_len, got.slice_len, want.remaining, got.remaining);
      end
    endfunction
  endclass

  logic                clk, rst_n;
  logic                in_valid, in_stall, out_valid, out_stall;
  pedf_pkg::in_beat_t  in_data;
  pedf_pkg::out_beat_t out_data;
  logic                cfg_wr_en;
  logic [15:0]         cfg_wr_data;

  sched_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int hold_cycles;

  priority_edf_slice_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // called at a falling edge; leaves in_valid high, the next idle or drain drops it
  task automatic send_beat(pedf_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_quantum(logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.quantum = v;
  endtask

  function automatic pedf_pkg::in_beat_t make_beat(bit m, int id, int lvl, int bu,
                                                   logic [31:0] dl);
    pedf_pkg::in_beat_t b;
    b.mode = m; b.task_id = 8'(id); b.priority_req = 3'(lvl); b.burst = 16'(bu);
    b.deadline = dl;
    return b;
  endfunction

  function automatic pedf_pkg::in_beat_t rand_beat();
    pedf_pkg::in_beat_t b;
    int r;
    b = pedf_pkg::in_beat_t'(60'({$urandom, $urandom}));
    b.mode = ($urandom_range(99) < 45);
    r = $urandom_range(9);
    b.priority_req = (r < 6) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
    r = $urandom_range(9);
    b.burst = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
              (r < 8) ? 16'($urandom_range(40)) : 16'($urandom);
    r = $urandom_range(9);
    if (r < 6) b.deadline = sb.now + $urandom_range(400);
    else if (r == 6) b.deadline = 32'hFFFF_FFFF;
    else if (r == 7) b.deadline = sb.now;
    return b;
  endfunction

  initial begin
    logic [15:0] qs[6];
    sb = new();
    sb.clear();
    rst_n = 0; in_valid = 0; in_data = '0; out_stall = 0;
    cfg_wr_en = 0; cfg_wr_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed beats at reset quantum, then at quantum FFFF and zero
    send_beat(make_beat(pedf_pkg::MODE_DISPATCH, 0, 0, 0, 0));
    send_beat(make_beat(pedf_pkg::MODE_ADD, 8'hFF, 7, 16'hFFFF, 32'hFFFF_FFFF));
    send_beat(make_beat(pedf_pkg::MODE_ADD, 1, 0, 0, 0));
    send_beat(make_beat(pedf_pkg::MODE_ADD, 2, 0, 25, 100));
    send_beat(make_beat(pedf_pkg::MODE_ADD, 3, 0, 5, 100));
    send_beat(make_beat(pedf_pkg::MODE_ADD, 4, 0, 20, 3));
    for (int i = 0; i < 6; i++) send_beat(make_beat(pedf_pkg::MODE_DISPATCH, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      send_beat(make_beat(pedf_pkg::MODE_ADD, i, 5, i, 32'hFFFF_FFFF - i));
    write_quantum(16'hFFFF);
    send_beat(make_beat(pedf_pkg::MODE_ADD, 9, 1, 16'hFFFF, 32'hFFFF_FFFF));
    send_beat(make_beat(pedf_pkg::MODE_DISPATCH, 0, 0, 0, 0));
    write_quantum(16'd0);
    send_beat(make_beat(pedf_pkg::MODE_DISPATCH, 0, 0, 0, 0));

    qs = '{16'd1, 16'd10, 16'd7, 16'd0, 16'hFFFF, 16'd3};
    for (int ph = 0; ph < 6; ph++) begin
      write_quantum(qs[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (ph == 1) begin
        @(negedge clk);
        hold_cycles <= 300;
      end
      for (int i = 0; i < 215; i++) begin
        send_beat(rand_beat());
        if (i == 100) drain();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
